/* rtl/tpc_pkg.sv */
package tpc_pkg;

    localparam int TABLE_ENTRIES  = 256;
    localparam int TEMP_FRAC_BITS = 4;
    localparam int IDX_W          = $clog2(TABLE_ENTRIES);
    localparam logic [8:0] TBL_LIMIT = 9'(TABLE_ENTRIES);

    localparam int HEAT_D_INT   = 550 << TEMP_FRAC_BITS;
    localparam int HEAT_OFF_INT = 50 << TEMP_FRAC_BITS;
    localparam int HEAT_W       = $clog2(HEAT_D_INT + 1);
    localparam int DEN_W        = (HEAT_W > 15) ? HEAT_W : 15;
    localparam int NUM_W        = DEN_W + 8;
    localparam int TS_W         = DEN_W + 2;
    localparam int Q_W          = 8;
    localparam int DIV_STAGES   = 4;
    localparam int DIV_STEP     = Q_W / DIV_STAGES;

    localparam logic [23:0] MAGENTA     = 24'hFF00FF;
    localparam logic [23:0] BG_RESET    = 24'h000000;
    localparam logic [7:0]  OVL_ALPHA   = 8'd160;
    localparam logic [7:0]  CRACK_GREY  = 8'd40;
    localparam logic [31:0] OOB_PIXEL   = 32'h000000FF;
    localparam logic [31:0] SOLID_DEBUG = 32'hFF000060;

    localparam logic [1:0] FUNC_MAT  = 2'd0;
    localparam logic [1:0] FUNC_BG   = 2'd1;
    localparam logic [1:0] FUNC_PIX  = 2'd2;
    localparam logic [1:0] FUNC_NONE = 2'd3;

    localparam logic [2:0] MODE_NONE   = 3'd0;
    localparam logic [2:0] MODE_HEAT   = 3'd1;
    localparam logic [2:0] MODE_HEALTH = 3'd2;
    localparam logic [2:0] MODE_CRACK  = 3'd3;
    localparam logic [2:0] MODE_STAIN  = 3'd4;
    localparam logic [2:0] MODE_DIAG   = 3'd5;
    localparam logic [2:0] MODE_RSVD   = 3'd7;

    localparam logic [1:0] CFG_MODE = 2'd0;
    localparam logic [1:0] CFG_SIM  = 2'd1;
    localparam logic [1:0] CFG_REG  = 2'd2;

    typedef struct packed {
        logic [1:0]         func;
        logic [7:0]         table_index;
        logic [23:0]        entry_color;
        logic               entry_flag;
        logic [14:0]        entry_hp_limit;
        logic [7:0]         cell_material;
        logic [7:0]         cell_background;
        logic               in_bounds;
        logic [31:0]        stain_rgba;
        logic signed [15:0] temperature;
        logic signed [15:0] health_value;
        logic [7:0]         crack_level;
    } in_word_t;

    typedef struct packed {
        logic [31:0] pixel_rgba;
        logic [31:0] collision_pixel;
    } out_word_t;

    typedef struct packed {
        logic [23:0] mat_color;
        logic        air;
        logic [14:0] hp_limit;
        logic [23:0] bg_color;
        logic        transparent;
    } tbl_rd_t;

    typedef logic [2:0][15:0] rgb_sum_t;

    function automatic rgb_sum_t blend_sum(logic [23:0] base, logic [23:0] src, logic [7:0] a);
        rgb_sum_t   r;
        logic [7:0] na;
        na = 8'd255 - a;
        for (int i = 0; i < 3; i++) begin
            r[i] = ({8'd0, base[8*i +: 8]} * {8'd0, na}) + ({8'd0, src[8*i +: 8]} * {8'd0, a});
        end
        return r;
    endfunction

    function automatic logic [23:0] div255_rgb(rgb_sum_t s);
        logic [23:0] o;
        logic [16:0] t;
        for (int i = 0; i < 3; i++) begin
            t = {1'b0, s[i]} + 17'd1 + {9'd0, s[i][15:8]};
            o[8*i +: 8] = t[15:8];
        end
        return o;
    endfunction

endpackage

/* rtl/tpc_tables.sv */
module tpc_tables (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  tpc_pkg::in_word_t  word,
    input  logic               rd_en,
    output tpc_pkg::tbl_rd_t   rd_data,
    output logic               busy
);
    import tpc_pkg::*;

    logic [39:0] mat_mem_reg [TABLE_ENTRIES];
    logic [24:0] bg_mem_reg  [TABLE_ENTRIES];
    logic [39:0] mat_q_reg;
    logic [24:0] bg_q_reg;
    logic        mat_hit_reg;
    logic        bg_hit_reg;
    logic             clr_busy_reg;
    logic [IDX_W-1:0] clr_idx_reg;

    logic             w_range;
    logic             mat_we;
    logic             bg_we;
    logic [IDX_W-1:0] widx;
    logic [IDX_W-1:0] midx;
    logic [IDX_W-1:0] bidx;
    logic             m_range;
    logic             b_range;

    assign w_range = {1'b0, word.table_index} < TBL_LIMIT;
    assign m_range = {1'b0, word.cell_material} < TBL_LIMIT;
    assign b_range = {1'b0, word.cell_background} < TBL_LIMIT;
    assign mat_we  = wr_en && (word.func == FUNC_MAT) && w_range;
    assign bg_we   = wr_en && (word.func == FUNC_BG) && w_range;
    assign widx    = word.table_index[IDX_W-1:0];
    assign midx    = word.cell_material[IDX_W-1:0];
    assign bidx    = word.cell_background[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mat_mem_reg[clr_idx_reg] <= {MAGENTA, 1'b0, 15'd0};
            bg_mem_reg[clr_idx_reg]  <= {BG_RESET, 1'b1};
        end
        else
        begin
            if (mat_we)
            begin
                mat_mem_reg[widx] <= {word.entry_color, word.entry_flag, word.entry_hp_limit};
            end
            if (bg_we)
            begin
                bg_mem_reg[widx] <= {word.entry_color, word.entry_flag};
            end
        end
        if (rd_en)
        begin
            mat_q_reg <= mat_mem_reg[midx];
            bg_q_reg  <= bg_mem_reg[bidx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
            mat_hit_reg  <= 1'b0;
            bg_hit_reg   <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == IDX_W'(TABLE_ENTRIES - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (rd_en)
            begin
                mat_hit_reg <= m_range;
                bg_hit_reg  <= b_range;
            end
        end
    end

    assign busy = clr_busy_reg;

    assign rd_data.mat_color   = mat_hit_reg ? mat_q_reg[39:16] : MAGENTA;
    assign rd_data.air         = mat_hit_reg ? mat_q_reg[15] : 1'b0;
    assign rd_data.hp_limit    = mat_hit_reg ? mat_q_reg[14:0] : 15'd0;
    assign rd_data.bg_color    = bg_hit_reg ? bg_q_reg[24:1] : BG_RESET;
    assign rd_data.transparent = bg_hit_reg ? bg_q_reg[0] : 1'b1;

endmodule

/* rtl/tpc_div.sv */
module tpc_div (
    input  logic                          clk,
    input  logic [tpc_pkg::DIV_STAGES-1:0] en,
    input  logic [tpc_pkg::NUM_W-1:0]      num,
    input  logic [tpc_pkg::DEN_W-1:0]      den,
    output logic [tpc_pkg::Q_W-1:0]        quo,
    output logic                           rem_zero
);
    import tpc_pkg::*;

    logic [NUM_W-1:0] rem_reg  [DIV_STAGES];
    logic [DEN_W-1:0] den_reg  [DIV_STAGES];
    logic [Q_W-1:0]   q_reg    [DIV_STAGES];
    logic [NUM_W-1:0] rem_next [DIV_STAGES];
    logic [DEN_W-1:0] den_next [DIV_STAGES];
    logic [Q_W-1:0]   q_next   [DIV_STAGES];

    always_comb
    begin
        logic [NUM_W-1:0] r;
        logic [NUM_W-1:0] t;
        logic [DEN_W-1:0] d;
        logic [Q_W-1:0]   q;
        int               k;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (s == 0)
            begin
                r = num;
                d = den;
                q = '0;
            end
            else
            begin
                r = rem_reg[(s == 0) ? 0 : s - 1];
                d = den_reg[(s == 0) ? 0 : s - 1];
                q = q_reg[(s == 0) ? 0 : s - 1];
            end
            for (int j = 0; j < DIV_STEP; j++)
            begin
                k = Q_W - 1 - s * DIV_STEP - j;
                t = NUM_W'(d) << k;
                if (r >= t)
                begin
                    r    = r - t;
                    q[k] = 1'b1;
                end
            end
            rem_next[s] = r;
            den_next[s] = d;
            q_next[s]   = q;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (en[s])
            begin
                rem_reg[s] <= rem_next[s];
                den_reg[s] <= den_next[s];
                q_reg[s]   <= q_next[s];
            end
        end
    end

    assign quo      = q_reg[DIV_STAGES-1];
    assign rem_zero = (rem_reg[DIV_STAGES-1] == '0);

endmodule

/* rtl/terrain_pixel_compositor_top.sv */
// Terrain pixel compositor.
// Input channel (in_valid / in_stall / in_word): one word per cell. func 0 and 1
// words write a material or background table entry and give no output; func 2
// words render one pixel; func 3 words are dropped.
// Output channel (out_valid / out_stall / out_word): one word per rendered
// pixel, in input order, RGBA8888 plus the collision debug pixel.
// Config port (cfg_wr_en / cfg_index / cfg_data): 0 overlay mode, 1 simulator
// present, 2 registry present. Write only while the pipeline is empty.
// Pipeline (eight register stages): table read, base and stain products, four
// divider stages (two quotient bits each), overlay products, divide by 255
// into the output register.
// Throughput: one word per cycle while in_stall is low; a table write may be
// followed by a pixel that reads it on the next cycle.
// Reset: config registers clear and the pipeline empties; in_stall then stays
// high while the tables are filled with their defaults (magenta, black, solid,
// transparent, zero health).
// Stall: each stage holds while the next one is full and held, so bubbles close
// up; in_stall rises only while the tables fill or every stage is full and held.
module terrain_pixel_compositor_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  tpc_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_stall,
    output tpc_pkg::out_word_t out_word,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [2:0]         cfg_data
);
    import tpc_pkg::*;

    localparam int NSTG = DIV_STAGES + 4;
    localparam int LAST_DIV = DIV_STAGES + 1;

    typedef enum logic [2:0] {
        OVL_FIXED,
        OVL_HEAT_LO,
        OVL_HEAT_HI,
        OVL_HEALTH_HI,
        OVL_HEALTH_LO
    } ovl_kind_t;

    typedef struct packed {
        logic        air;
        logic        in_bounds;
        ovl_kind_t   kind;
        logic [23:0] color;
        logic [7:0]  alpha;
    } side_t;

    logic [2:0] mode_reg;
    logic       sim_reg;
    logic       regp_reg;

    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] en;
    logic            accept;
    logic            clr_busy;

    in_word_t    f1_reg;
    tbl_rd_t     rd;
    side_t       side_reg [1:LAST_DIV];
    rgb_sum_t    sum1_reg;
    logic [23:0] base_reg [2:LAST_DIV];
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    rgb_sum_t    sum6_reg;
    logic        air6_reg;
    logic        inb6_reg;
    out_word_t   out_reg;

    logic [Q_W-1:0] quo;
    logic           rem_zero;

    side_t            side_next;
    rgb_sum_t         sum1_next;
    logic [NUM_W-1:0] num_next;
    logic [DEN_W-1:0] den_next;
    rgb_sum_t         sum6_next;
    out_word_t        out_next;

    assign accept   = in_valid && !in_stall;
    assign in_stall = !en[0] || clr_busy;

    always_comb
    begin
        en[NSTG-1] = !v_reg[NSTG-1] || !out_stall;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= '0;
            sim_reg  <= 1'b0;
            regp_reg <= 1'b0;
            v_reg    <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_MODE: mode_reg <= cfg_data;
                    CFG_SIM:  sim_reg  <= cfg_data[0];
                    CFG_REG:  regp_reg <= cfg_data[0];
                    default:  ;
                endcase
            end
            if (en[0])
            begin
                v_reg[0] <= accept && (in_word.func == FUNC_PIX);
            end
            for (int i = 1; i < NSTG; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    tpc_tables u_tables (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .word    (in_word),
        .rd_en   (en[0]),
        .rd_data (rd),
        .busy    (clr_busy)
    );

    always_comb
    begin
        logic [23:0]            base;
        logic [7:0]             sa;
        logic [7:0]             stain_a;
        logic signed [TS_W-1:0] st;
        logic [DEN_W-1:0]       sc;
        logic [DEN_W:0]         two_s;
        logic [DEN_W-1:0]       a;
        logic [14:0]            h;
        logic [15:0]            two_h;
        base    = (rd.air && !rd.transparent) ? rd.bg_color : rd.mat_color;
        sa      = f1_reg.stain_rgba[7:0];
        stain_a = (sim_reg && mode_reg != MODE_STAIN) ? sa : 8'd0;
        sum1_next = blend_sum(base, f1_reg.stain_rgba[31:8], stain_a);

        side_next.air       = rd.air;
        side_next.in_bounds = f1_reg.in_bounds;
        side_next.kind      = OVL_FIXED;
        side_next.color     = '0;
        side_next.alpha     = '0;
        a        = '0;
        den_next = DEN_W'(HEAT_D_INT);

        st = TS_W'(f1_reg.temperature) + TS_W'(HEAT_OFF_INT);
        if (st < 0)
        begin
            sc = '0;
        end
        else if (st > TS_W'(HEAT_D_INT))
        begin
            sc = DEN_W'(HEAT_D_INT);
        end
        else
        begin
            sc = st[DEN_W-1:0];
        end
        two_s = {sc, 1'b0};

        if (f1_reg.health_value < 0)
        begin
            h = '0;
        end
        else if (f1_reg.health_value[14:0] > rd.hp_limit)
        begin
            h = rd.hp_limit;
        end
        else
        begin
            h = f1_reg.health_value[14:0];
        end
        two_h = {h, 1'b0};

        if (sim_reg)
        begin
            case (mode_reg)
                MODE_HEAT:
                begin
                    side_next.alpha = OVL_ALPHA;
                    if (two_s < (DEN_W+1)'(HEAT_D_INT))
                    begin
                        side_next.kind = OVL_HEAT_LO;
                        a = two_s[DEN_W-1:0];
                    end
                    else
                    begin
                        side_next.kind = OVL_HEAT_HI;
                        a = DEN_W'(two_s - (DEN_W+1)'(HEAT_D_INT));
                    end
                end
                MODE_HEALTH:
                begin
                    if (regp_reg && rd.hp_limit != '0)
                    begin
                        side_next.alpha = OVL_ALPHA;
                        den_next = DEN_W'(rd.hp_limit);
                        if (two_h > {1'b0, rd.hp_limit})
                        begin
                            side_next.kind = OVL_HEALTH_HI;
                            a = DEN_W'(two_h - {1'b0, rd.hp_limit});
                        end
                        else
                        begin
                            side_next.kind = OVL_HEALTH_LO;
                            a = DEN_W'(two_h);
                        end
                    end
                end
                MODE_CRACK:
                begin
                    side_next.color = {CRACK_GREY, CRACK_GREY, CRACK_GREY};
                    side_next.alpha = f1_reg.crack_level;
                end
                MODE_STAIN:
                begin
                    side_next.color = f1_reg.stain_rgba[31:8];
                    side_next.alpha = sa;
                end
                default: ;
            endcase
        end
        num_next = (NUM_W'(a) << 8) - NUM_W'(a);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            f1_reg <= in_word;
        end
        if (en[1])
        begin
            side_reg[1] <= side_next;
            sum1_reg    <= sum1_next;
            num_reg     <= num_next;
            den_reg     <= den_next;
        end
        if (en[2])
        begin
            side_reg[2] <= side_reg[1];
            base_reg[2] <= div255_rgb(sum1_reg);
        end
        for (int i = 3; i <= LAST_DIV; i++)
        begin
            if (en[i])
            begin
                side_reg[i] <= side_reg[i-1];
                base_reg[i] <= base_reg[i-1];
            end
        end
        if (en[NSTG-2])
        begin
            sum6_reg <= sum6_next;
            air6_reg <= side_reg[LAST_DIV].air;
            inb6_reg <= side_reg[LAST_DIV].in_bounds;
        end
        if (en[NSTG-1])
        begin
            out_reg <= out_next;
        end
    end

    tpc_div u_div (
        .clk      (clk),
        .en       (en[LAST_DIV:2]),
        .num      (num_reg),
        .den      (den_reg),
        .quo      (quo),
        .rem_zero (rem_zero)
    );

    always_comb
    begin
        logic [7:0]  comp;
        logic [23:0] ovl;
        side_t       sd;
        sd   = side_reg[LAST_DIV];
        comp = (rem_zero ? 8'd255 : 8'd254) - quo;
        case (sd.kind)
            OVL_HEAT_LO:   ovl = {8'd0, quo, comp};
            OVL_HEAT_HI:   ovl = {quo, comp, 8'd0};
            OVL_HEALTH_HI: ovl = {8'd255, quo, quo};
            OVL_HEALTH_LO: ovl = {quo, 16'd0};
            default:       ovl = sd.color;
        endcase
        sum6_next = blend_sum(base_reg[LAST_DIV], ovl, sd.alpha);
    end

    always_comb
    begin
        if (inb6_reg)
        begin
            out_next.pixel_rgba      = {div255_rgb(sum6_reg), 8'hFF};
            out_next.collision_pixel = air6_reg ? 32'd0 : SOLID_DEBUG;
        end
        else
        begin
            out_next.pixel_rgba      = OOB_PIXEL;
            out_next.collision_pixel = 32'd0;
        end
    end

    assign out_valid = v_reg[NSTG-1];
    assign out_word  = out_reg;

endmodule

/* rtl/tpc_checker.sv */
module tpc_assertions (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input tpc_pkg::out_word_t out_word
);
    import tpc_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("output word changed under stall");

    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_word.pixel_rgba[7:0] == 8'hFF)
        else $error("output alpha not opaque");

    a_debug: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_word.collision_pixel == 32'd0 ||
                      out_word.collision_pixel == SOLID_DEBUG)
        else $error("bad collision pixel");

    a_oob: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.pixel_rgba == OOB_PIXEL |->
            out_word.collision_pixel == 32'd0 || out_word.collision_pixel == SOLID_DEBUG)
        else $error("bad pixel for black output");

endmodule

bind terrain_pixel_compositor_top tpc_assertions u_tpc_assertions (.*);
